FILE: hdl/lfpd_pkg.sv
package lfpd_pkg;

	localparam int PIN_W     = 5;
	localparam int TIME_W    = 32;
	localparam int ECHO_W    = 20;
	localparam int DUTY_W    = 8;
	localparam int GAIN_W    = 8;
	localparam int POS_W     = 11;
	localparam int ERR_W     = 12;
	localparam int DIFF_W    = 13;
	localparam int DRIVE_W   = 16;

	localparam int MUL_A_W   = 19;
	localparam int MUL_B_W   = 32;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int MUL_CNT_W = $clog2(MUL_A_W + 1);

	localparam int KDD_W     = 20;
	localparam int KMAG_W    = 30;
	localparam int KS_W      = KMAG_W + 1;
	localparam int NUM_W     = 53;

	localparam int DIV_N_W   = NUM_W - 1;
	localparam int DIV_D_W   = 32;
	localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

	localparam int THR_W     = 15;
	localparam int APB_AW    = 5;
	localparam int APB_DW    = 32;

	localparam logic [9:0]         MS_PER_S    = 10'd1000;
	localparam logic [5:0]         US_PER_CM   = 6'd58;
	localparam logic [DRIVE_W-1:0] DRIVE_POS_SAT = 16'h7fff;
	localparam logic [DRIVE_W-1:0] DRIVE_NEG_SAT = 16'h8000;

	localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
	localparam logic [2:0] REG_DERIV_GAIN  = 3'd1;
	localparam logic [2:0] REG_CENTER      = 3'd2;
	localparam logic [2:0] REG_CRUISE_DUTY = 3'd3;
	localparam logic [2:0] REG_MAX_SPEED   = 3'd4;
	localparam logic [2:0] REG_STOP_DIST   = 3'd5;

	localparam logic [GAIN_W-1:0] RST_PROP_GAIN   = 8'd120;
	localparam logic [GAIN_W-1:0] RST_DERIV_GAIN  = 8'd35;
	localparam logic [POS_W-1:0]  RST_CENTER      = 11'd512;
	localparam logic [DUTY_W-1:0] RST_CRUISE_DUTY = 8'd60;
	localparam logic [DUTY_W-1:0] RST_MAX_SPEED   = 8'd100;
	localparam logic [7:0]        RST_STOP_DIST   = 8'd10;

	// 65536 / count, rounded up, for the centroid
	localparam logic [16:0] CNT_RECIP [8] = '{
		17'd0, 17'd65536, 17'd32768, 17'd21846, 17'd16384, 17'd13108, 17'd0, 17'd0
	};

	typedef struct packed {
		logic [GAIN_W-1:0] prop_gain;
		logic [GAIN_W-1:0] deriv_gain;
		logic [POS_W-1:0]  center_target;
		logic [DUTY_W-1:0] cruise_duty;
		logic [DUTY_W-1:0] max_speed;
		logic [7:0]        stop_distance_cm;
	} cfg_t;

	typedef struct packed {
		logic             all_seen;
		logic [POS_W-1:0] centroid;
	} decode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL,
		ST_COMB,
		ST_DLOAD,
		ST_DIV,
		ST_SAT,
		ST_OUT
	} seq_state_t;

	function automatic decode_t lfpd_decode(input logic [PIN_W-1:0] pins);
		logic [PIN_W-1:0] seen;
		logic [2:0]       cnt;
		logic [3:0]       wsum;
		logic [20:0]      prod;
		decode_t          d;
		seen = ~pins;
		if (seen[1]) seen[0] = 1'b1;
		if (seen[3]) seen[4] = 1'b1;
		cnt  = '0;
		wsum = '0;
		for (int i = 0; i < PIN_W; i++) begin
			if (seen[i]) begin
				cnt  = cnt + 3'd1;
				wsum = wsum + 4'(i);
			end
		end
		prod       = {17'b0, wsum} * {4'b0, CNT_RECIP[cnt]};
		d.centroid = prod[18:8];
		d.all_seen = (cnt == 3'd5);
		return d;
	endfunction

endpackage

FILE: hdl/lfpd_regs.sv
module lfpd_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [lfpd_pkg::APB_AW-1:0] paddr,
	input  logic [lfpd_pkg::APB_DW-1:0] pwdata,
	output logic [lfpd_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output lfpd_pkg::cfg_t             cfg
);
	import lfpd_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[APB_AW-1:2];
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain        <= RST_PROP_GAIN;
			cfg_q.deriv_gain       <= RST_DERIV_GAIN;
			cfg_q.center_target    <= RST_CENTER;
			cfg_q.cruise_duty      <= RST_CRUISE_DUTY;
			cfg_q.max_speed        <= RST_MAX_SPEED;
			cfg_q.stop_distance_cm <= RST_STOP_DIST;
		end else if (wr_en) begin
			case (idx)
				REG_PROP_GAIN:   cfg_q.prop_gain        <= pwdata[GAIN_W-1:0];
				REG_DERIV_GAIN:  cfg_q.deriv_gain       <= pwdata[GAIN_W-1:0];
				REG_CENTER:      cfg_q.center_target    <= pwdata[POS_W-1:0];
				REG_CRUISE_DUTY: cfg_q.cruise_duty      <= pwdata[DUTY_W-1:0];
				REG_MAX_SPEED:   cfg_q.max_speed        <= pwdata[DUTY_W-1:0];
				REG_STOP_DIST:   cfg_q.stop_distance_cm <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_PROP_GAIN:   prdata = {24'b0, cfg_q.prop_gain};
			REG_DERIV_GAIN:  prdata = {24'b0, cfg_q.deriv_gain};
			REG_CENTER:      prdata = {21'b0, cfg_q.center_target};
			REG_CRUISE_DUTY: prdata = {24'b0, cfg_q.cruise_duty};
			REG_MAX_SPEED:   prdata = {24'b0, cfg_q.max_speed};
			REG_STOP_DIST:   prdata = {24'b0, cfg_q.stop_distance_cm};
			default:         prdata = '0;
		endcase
	end

endmodule

FILE: hdl/lfpd_serial_mul.sv
module lfpd_serial_mul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [lfpd_pkg::MUL_A_W-1:0] a,
	input  logic [lfpd_pkg::MUL_B_W-1:0] b,
	output logic                         busy,
	output logic [lfpd_pkg::MUL_P_W-1:0] product
);
	import lfpd_pkg::*;

	logic [MUL_P_W-1:0]   acc_q;
	logic [MUL_B_W-1:0]   b_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic [MUL_B_W:0]     sum;
	logic [MUL_P_W-1:0]   acc_next;

	// shift-add, one multiplier bit per cycle, low bit first
	always_comb begin
		sum = {1'b0, acc_q[MUL_P_W-1:MUL_A_W]} + {1'b0, b_q};
		if (acc_q[0]) begin
			acc_next = {sum, acc_q[MUL_A_W-1:1]};
		end else begin
			acc_next = {1'b0, acc_q[MUL_P_W-1:MUL_A_W], acc_q[MUL_A_W-1:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= MUL_CNT_W'(MUL_A_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - MUL_CNT_W'(1);
			if (cnt_q == MUL_CNT_W'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= {{MUL_B_W{1'b0}}, a};
			b_q   <= b;
		end else if (busy_q) begin
			acc_q <= acc_next;
		end
	end

	assign busy    = busy_q;
	assign product = acc_q;

endmodule

FILE: hdl/lfpd_serial_div.sv
module lfpd_serial_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [lfpd_pkg::DIV_N_W-1:0] num,
	input  logic [lfpd_pkg::DIV_D_W-1:0] den,
	output logic                         busy,
	output logic [lfpd_pkg::DIV_N_W-1:0] quotient
);
	import lfpd_pkg::*;

	logic [DIV_D_W-1:0]   rem_q;
	logic [DIV_D_W-1:0]   den_q;
	logic [DIV_N_W-1:0]   quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic [DIV_D_W:0]     trial;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quo_q[DIV_N_W-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DIV_N_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[DIV_D_W]) begin
				rem_q <= trial[DIV_D_W-1:0];
				quo_q <= {quo_q[DIV_N_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DIV_D_W-2:0], quo_q[DIV_N_W-1]};
				quo_q <= {quo_q[DIV_N_W-2:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

FILE: hdl/line_follow_pd_drive_top.sv
// PD line follower drive with obstacle stop. Each transfer on the input channel
// brings the five sensor pin levels, a millisecond time stamp and an echo time,
// and yields one result: both motor duties, the obstacle flag, the Q8 position
// error and the PD drive that was applied. One item is worked on at a time: the
// next input transfer waits until the bit-serial multiplier (gain*error times
// elapsed ms) and the bit-serial restoring divider (the division by elapsed ms)
// have finished with it. A finished result sits in the output register, so a
// stalled output only holds the block once the following item is done. Gains,
// setpoint, speeds and stop distance are to be written over the APB port only
// while no item is in flight; the block itself does not enforce this.
module line_follow_pd_drive_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [lfpd_pkg::PIN_W-1:0]   pin_levels,
	input  logic [lfpd_pkg::TIME_W-1:0]  now_ms,
	input  logic [lfpd_pkg::ECHO_W-1:0]  echo_us,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [lfpd_pkg::DUTY_W-1:0]  right_duty,
	output logic [lfpd_pkg::DUTY_W-1:0]  left_duty,
	output logic                         obstacle,
	output logic signed [lfpd_pkg::ERR_W-1:0]   position_error,
	output logic signed [lfpd_pkg::DRIVE_W-1:0] drive_value,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lfpd_pkg::APB_AW-1:0]  paddr,
	input  logic [lfpd_pkg::APB_DW-1:0]  pwdata,
	output logic [lfpd_pkg::APB_DW-1:0]  prdata,
	output logic                         pready
);
	import lfpd_pkg::*;

	cfg_t       cfg;
	seq_state_t state_q, state_nxt;

	logic in_take, mul_start, div_start, out_load;

	// per-item working registers
	logic [ERR_W-1:0]   err_q;
	logic [DIFF_W-1:0]  diff_q;
	logic [TIME_W-1:0]  dt_q;
	logic               dt_zero_q;
	logic               all_q;
	logic               obst_q;
	logic [KDD_W-1:0]   kdd_q;
	logic [KMAG_W-1:0]  kmag_q;
	logic [KS_W-1:0]    ks_q;
	logic [NUM_W-1:0]   num_q;
	logic               neg_q;
	logic               sat_q;
	logic [DRIVE_W-1:0] drive_q;

	// state carried between items
	logic [ERR_W-1:0]   prev_err_q;
	logic [TIME_W-1:0]  prev_time_q;
	logic [DRIVE_W-1:0] held_q;

	logic               out_valid_q;
	logic [DUTY_W-1:0]  out_right_q, out_left_q;
	logic               out_obst_q;
	logic [ERR_W-1:0]   out_err_q;
	logic [DRIVE_W-1:0] out_drive_q;

	decode_t            dec;
	logic [ERR_W-1:0]   err_in;
	logic [DIFF_W-1:0]  diff_in;
	logic [THR_W-1:0]   echo_thr;
	logic [POS_W-1:0]   err_mag;
	logic [ERR_W-1:0]   diff_mag;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] dt_eff;
	logic               mul_busy, div_busy;
	logic [MUL_P_W-1:0] product;
	logic [DIV_N_W-1:0] quotient;
	logic [DIV_N_W-1:0] num_mag;
	logic [NUM_W-1:0]   prod_signed;
	logic [DIV_N_W-9:0] drv_mag;
	logic [DRIVE_W-1:0] drv_new;
	logic [17:0]        right_sum, left_sum;
	logic [DUTY_W-1:0]  right_clamp, left_clamp;

	lfpd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// front end on the transfer
	always_comb begin
		dec      = lfpd_decode(pin_levels);
		err_in   = {1'b0, cfg.center_target} - {1'b0, dec.centroid};
		diff_in  = {err_in[ERR_W-1], err_in} - {prev_err_q[ERR_W-1], prev_err_q};
		echo_thr = THR_W'(({7'b0, cfg.stop_distance_cm} + 15'd1) * {9'b0, US_PER_CM});
	end

	always_comb begin
		err_mag  = err_q[ERR_W-1] ? POS_W'(-err_q) : err_q[POS_W-1:0];
		diff_mag = diff_q[DIFF_W-1] ? ERR_W'(-diff_q) : diff_q[ERR_W-1:0];
		mul_a    = {11'b0, cfg.prop_gain} * {8'b0, err_mag};
		dt_eff   = dt_zero_q ? MUL_B_W'(1) : dt_q;
	end

	lfpd_serial_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (dt_eff),
		.busy    (mul_busy),
		.product (product)
	);

	always_comb begin
		prod_signed = err_q[ERR_W-1] ? -{2'b0, product} : {2'b0, product};
		num_mag     = num_q[NUM_W-1] ? DIV_N_W'(-num_q) : num_q[DIV_N_W-1:0];
	end

	lfpd_serial_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (num_mag),
		.den      (dt_eff),
		.busy     (div_busy),
		.quotient (quotient)
	);

	// saturate the divided drive
	always_comb begin
		drv_mag = quotient[DIV_N_W-1:8];
		if (sat_q) begin
			drv_new = ks_q[KS_W-1] ? DRIVE_NEG_SAT : DRIVE_POS_SAT;
		end else if (neg_q) begin
			if (drv_mag > (DIV_N_W-8)'(32768)) drv_new = DRIVE_NEG_SAT;
			else drv_new = DRIVE_W'(-drv_mag[DRIVE_W-1:0]);
		end else begin
			if (drv_mag > (DIV_N_W-8)'(32767)) drv_new = DRIVE_POS_SAT;
			else drv_new = drv_mag[DRIVE_W-1:0];
		end
	end

	// duty clamp
	always_comb begin
		right_sum = {10'b0, cfg.cruise_duty} + {{2{drive_q[DRIVE_W-1]}}, drive_q};
		left_sum  = {10'b0, cfg.cruise_duty} - {{2{drive_q[DRIVE_W-1]}}, drive_q};
		if (right_sum[17]) right_clamp = '0;
		else if (right_sum > {10'b0, cfg.max_speed}) right_clamp = cfg.max_speed;
		else right_clamp = right_sum[DUTY_W-1:0];
		if (left_sum[17]) left_clamp = '0;
		else if (left_sum > {10'b0, cfg.max_speed}) left_clamp = cfg.max_speed;
		else left_clamp = left_sum[DUTY_W-1:0];
	end

	// sequencer: next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_nxt = ST_PREP;
			ST_PREP:  state_nxt = ST_MUL;
			ST_MUL:   if (!mul_busy) state_nxt = ST_COMB;
			ST_COMB:  state_nxt = ST_DLOAD;
			ST_DLOAD: state_nxt = ST_DIV;
			ST_DIV:   if (!div_busy) state_nxt = ST_SAT;
			ST_SAT:   state_nxt = ST_OUT;
			ST_OUT:   if (!out_valid_q || !out_stall) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		in_stall  = 1'b1;
		mul_start = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE:  in_stall  = 1'b0;
			ST_PREP:  mul_start = 1'b1;
			ST_DLOAD: div_start = 1'b1;
			ST_OUT:   out_load  = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	assign in_take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_err_q  <= '0;
			prev_time_q <= '0;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (in_take) begin
				prev_err_q  <= err_in;
				prev_time_q <= now_ms;
			end
			if (state_q == ST_SAT && !all_q) held_q <= drv_new;
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			err_q     <= err_in;
			diff_q    <= diff_in;
			dt_q      <= now_ms - prev_time_q;
			dt_zero_q <= (now_ms == prev_time_q);
			all_q     <= dec.all_seen;
			obst_q    <= ({5'b0, echo_thr} > echo_us);
		end
		if (state_q == ST_PREP) kdd_q <= {12'b0, cfg.deriv_gain} * {8'b0, diff_mag};
		if (state_q == ST_MUL) begin
			kmag_q <= {10'b0, kdd_q} * {20'b0, MS_PER_S};
			ks_q   <= diff_q[DIFF_W-1] ? -{1'b0, kmag_q} : {1'b0, kmag_q};
		end
		if (state_q == ST_COMB) begin
			num_q <= prod_signed + {{(NUM_W-KS_W){ks_q[KS_W-1]}}, ks_q};
			sat_q <= dt_zero_q && (ks_q != '0);
		end
		if (state_q == ST_DLOAD) neg_q <= num_q[NUM_W-1];
		if (state_q == ST_SAT) drive_q <= all_q ? held_q : drv_new;
		if (out_load) begin
			out_right_q <= obst_q ? '0 : right_clamp;
			out_left_q  <= obst_q ? '0 : left_clamp;
			out_obst_q  <= obst_q;
			out_err_q   <= err_q;
			out_drive_q <= drive_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign right_duty     = out_right_q;
	assign left_duty      = out_left_q;
	assign obstacle       = out_obst_q;
	assign position_error = $signed(out_err_q);
	assign drive_value    = $signed(out_drive_q);

`ifndef SYNTH
	a_obst_stops: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && obstacle |-> right_duty == '0 && left_duty == '0)
		else $error("obstacle result with nonzero duty");

	a_take_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second transfer while an item is in flight");

	a_mul_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_busy |-> state_q == ST_MUL)
		else $error("multiplier running outside its step");

	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> state_q == ST_DIV)
		else $error("divider running outside its step");
`endif

endmodule

FILE: verif/tb_line_follow_pd_drive_top.sv
module tb_line_follow_pd_drive_top;
	import lfpd_pkg::*;

	localparam longint DRV_HI = 32767;
	localparam longint DRV_LO = -32768;
	localparam longint MS_SCALE = 1000;
	localparam int ECHO_PER_CM = 58;
	localparam int QUIET_LIMIT = 4000;
	localparam int PHASES = 6;
	localparam int RAND_PER_PHASE = 90;
	localparam int DIR_ROWS = 14;

	typedef struct packed {
		logic [DUTY_W-1:0]         right;
		logic [DUTY_W-1:0]         left;
		logic                      obs;
		logic signed [ERR_W-1:0]   err;
		logic signed [DRIVE_W-1:0] drv;
	} duty_res_t;

	typedef struct packed {
		logic [PIN_W-1:0]  pins;
		logic [TIME_W-1:0] ms;
		logic [ECHO_W-1:0] echo;
		logic              known;
		duty_res_t         res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [PIN_W-1:0] pin_levels = '0;
	logic [TIME_W-1:0] now_ms = '0;
	logic [ECHO_W-1:0] echo_us = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [DUTY_W-1:0] right_duty;
	logic [DUTY_W-1:0] left_duty;
	logic obstacle;
	logic signed [ERR_W-1:0] position_error;
	logic signed [DRIVE_W-1:0] drive_value;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic pready;

	// side data that travels with the payload of a table row
	logic row_known = 1'b0;
	duty_res_t row_res = '0;

	// predictor copy of the block
	cfg_t cur_cfg = '{RST_PROP_GAIN, RST_DERIV_GAIN, RST_CENTER, RST_CRUISE_DUTY,
		RST_MAX_SPEED, RST_STOP_DIST};
	int last_err = 0;
	logic [TIME_W-1:0] last_ms = '0;
	longint hold_drive = 0;

	duty_res_t pending_duties[$];
	int fail_count = 0;
	int quiet_cycles = 0;
	int stall_left = 0;
	bit idle_on = 1'b1;
	logic [TIME_W-1:0] stim_ms = '0;

	line_follow_pd_drive_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pin_levels(pin_levels),
		.now_ms(now_ms),
		.echo_us(echo_us),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.right_duty(right_duty),
		.left_duty(left_duty),
		.obstacle(obstacle),
		.position_error(position_error),
		.drive_value(drive_value),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint clamp_duty(input longint v);
		if (v < 0) return 0;
		if (v > longint'(cur_cfg.max_speed)) return longint'(cur_cfg.max_speed);
		return v;
	endfunction

	function automatic duty_res_t predict_drive(input logic [PIN_W-1:0] pins,
			input logic [TIME_W-1:0] t, input logic [ECHO_W-1:0] echo);
		logic [PIN_W-1:0] seen;
		int cnt;
		int wsum;
		int centroid;
		int err;
		int diff;
		logic [TIME_W-1:0] dt;
		longint kp;
		longint num;
		longint drv;
		logic obs;
		duty_res_t r;
		seen = ~pins;
		if (seen[1]) seen[0] = 1'b1;
		if (seen[3]) seen[4] = 1'b1;
		cnt = 0;
		wsum = 0;
		for (int k = 0; k < PIN_W; k++) begin
			if (seen[k]) begin
				cnt++;
				wsum += k;
			end
		end
		centroid = (cnt != 0) ? (wsum * 256) / cnt : 0;
		err = int'(cur_cfg.center_target) - centroid;
		diff = err - last_err;
		dt = t - last_ms;
		last_ms = t;
		last_err = err;
		kp = longint'(cur_cfg.prop_gain) * err;
		if (dt != 0) begin
			num = kp * longint'(dt) + longint'(cur_cfg.deriv_gain) * diff * MS_SCALE;
			drv = num / (longint'(dt) * 256);
		end else if (diff == 0 || cur_cfg.deriv_gain == 0) begin
			drv = kp / 256;
		end else begin
			drv = (diff > 0) ? DRV_HI : DRV_LO;
		end
		if (drv > DRV_HI) drv = DRV_HI;
		if (drv < DRV_LO) drv = DRV_LO;
		// everything seen: reuse the last drive
		if (cnt == 5) drv = hold_drive;
		else hold_drive = drv;
		obs = (echo / ECHO_PER_CM) <= cur_cfg.stop_distance_cm;
		r.right = obs ? '0 : DUTY_W'(clamp_duty(longint'(cur_cfg.cruise_duty) + drv));
		r.left = obs ? '0 : DUTY_W'(clamp_duty(longint'(cur_cfg.cruise_duty) - drv));
		r.obs = obs;
		r.err = ERR_W'(err);
		r.drv = DRIVE_W'(drv);
		return r;
	endfunction

	function automatic void check_field(input string name, input longint want,
			input longint got);
		if (want != got) begin
			$error("%s expected %0d got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		duty_res_t r;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				r = predict_drive(pin_levels, now_ms, echo_us);
				if (row_known) r = row_res;
				pending_duties.push_back(r);
			end
			if (out_valid && !out_stall) begin
				if (pending_duties.size() == 0) begin
					$error("result transfer with nothing pending");
					fail_count++;
				end else begin
					r = pending_duties.pop_front();
					check_field("right_duty", r.right, right_duty);
					check_field("left_duty", r.left, left_duty);
					check_field("obstacle", r.obs, obstacle);
					check_field("position_error", r.err, position_error);
					check_field("drive_value", r.drv, drive_value);
				end
			end
		end
		if (stall_left == 0 && idle_on && $urandom_range(0, 9) == 0)
			stall_left = $urandom_range(1, 17);
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic apb_write(input logic [2:0] idx, input logic [APB_DW-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_cfg(input cfg_t c);
		apb_write(REG_PROP_GAIN, APB_DW'(c.prop_gain));
		apb_write(REG_DERIV_GAIN, APB_DW'(c.deriv_gain));
		apb_write(REG_CENTER, APB_DW'(c.center_target));
		apb_write(REG_CRUISE_DUTY, APB_DW'(c.cruise_duty));
		apb_write(REG_MAX_SPEED, APB_DW'(c.max_speed));
		apb_write(REG_STOP_DIST, APB_DW'(c.stop_distance_cm));
		cur_cfg = c;
	endtask

	task automatic send_item(input logic [PIN_W-1:0] p, input logic [TIME_W-1:0] t,
			input logic [ECHO_W-1:0] e, input logic known, input duty_res_t x);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 17);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pin_levels <= p;
		now_ms <= t;
		echo_us <= e;
		row_known <= known;
		row_res <= x;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_random();
		logic [TIME_W-1:0] t;
		logic [ECHO_W-1:0] e;
		int thr;
		case ($urandom_range(0, 15))
			0: t = stim_ms;
			1: t = $urandom;
			2: t = 32'hFFFF_FFFF - $urandom_range(0, 30);
			default: t = stim_ms + $urandom_range(1, 40);
		endcase
		stim_ms = t;
		thr = int'(cur_cfg.stop_distance_cm) * ECHO_PER_CM;
		case ($urandom_range(0, 9))
			0: e = '0;
			1, 2: e = ECHO_W'($urandom_range(0, 20'hFFFFF));
			3, 4, 5: e = ECHO_W'(thr + $urandom_range(0, 2 * ECHO_PER_CM - 1));
			default: e = ECHO_W'($urandom_range(600, 30000));
		endcase
		send_item(PIN_W'($urandom_range(0, 31)), t, e, 1'b0, '0);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_duties.size() != 0) @(posedge clk);
	endtask

	initial begin
		stim_row_t dir_rows [DIR_ROWS];
		cfg_t phase_cfg [PHASES];
		dir_rows[0] = '{5'b11011, 32'd0, 20'hFFFFF, 1'b1,
			'{8'd60, 8'd60, 1'b0, 12'sd0, 16'sd0}};
		// nothing seen at zero elapsed time, echo time zero so an obstacle
		dir_rows[1] = '{5'b11111, 32'd0, 20'd0, 1'b1,
			'{8'd0, 8'd0, 1'b1, 12'sd512, 16'sd32767}};
		dir_rows[2] = '{5'b00000, 32'd0, 20'd638, 1'b1,
			'{8'd100, 8'd0, 1'b0, 12'sd0, 16'sd32767}};
		dir_rows[3] = '{5'b11110, 32'd1000, 20'd637, 1'b1,
			'{8'd0, 8'd0, 1'b1, 12'sd512, 16'sd310}};
		dir_rows[4] = '{5'b01111, 32'd2000, 20'd638, 1'b1,
			'{8'd0, 8'd100, 1'b0, -12'sd512, -16'sd380}};
		dir_rows[5] = '{5'b11101, 32'd2010, 20'd20000, 1'b0, '0};
		dir_rows[6] = '{5'b10111, 32'd2020, 20'd20000, 1'b0, '0};
		dir_rows[7] = '{5'b10101, 32'd2020, 20'd20000, 1'b0, '0};
		dir_rows[8] = '{5'b10101, 32'd2020, 20'd20000, 1'b0, '0};
		dir_rows[9] = '{5'b00000, 32'd2500, 20'hFFFFF, 1'b0, '0};
		dir_rows[10] = '{5'b11011, 32'hFFFF_FFFF, 20'd1000, 1'b0, '0};
		dir_rows[11] = '{5'b11001, 32'd5, 20'd1000, 1'b0, '0};
		dir_rows[12] = '{5'b00100, 32'd6, 20'd57, 1'b0, '0};
		dir_rows[13] = '{5'b11111, 32'h7FFF_FFFF, 20'd580, 1'b0, '0};

		phase_cfg[0] = cur_cfg;
		phase_cfg[1] = '{8'd255, 8'd255, 11'd2047, 8'd255, 8'd255, 8'd255};
		phase_cfg[2] = '{8'd0, 8'd0, 11'd0, 8'd0, 8'd0, 8'd0};
		phase_cfg[3] = '{8'($urandom), 8'($urandom), 11'($urandom_range(0, 1024)),
			8'($urandom), 8'($urandom), 8'($urandom_range(0, 40))};
		phase_cfg[4] = '{8'd1, 8'd255, 11'd1024, 8'd128, 8'd200, 8'd1};
		phase_cfg[5] = '{8'd120, 8'd35, 11'd512, 8'd60, 8'd100, 8'd10};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) write_cfg(phase_cfg[ph]);
			if (ph == 0) begin
				for (int i = 0; i < DIR_ROWS; i++) begin
					send_item(dir_rows[i].pins, dir_rows[i].ms, dir_rows[i].echo,
						dir_rows[i].known, dir_rows[i].res);
					stim_ms = dir_rows[i].ms;
				end
			end
			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				if (n % 20 == 0) idle_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
				// hold off mid stream until the block has emptied
				if (ph == 2 && n == 45) wait_drained();
				send_random();
			end
			wait_drained();
		end

		repeat (200) @(posedge clk);
		if (pending_duties.size() != 0) $error("%0d results never arrived", pending_duties.size());
		if (fail_count == 0 && pending_duties.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
